>>> hdl/ws_enc_pkg.sv
`timescale 1ns / 1ps
package ws_enc_pkg;

    // Bytes per color word; a fourth byte, if present, is sent as zeros after blue.
    localparam int COLOR_BYTES = 3;
    localparam int NUM_BITS    = COLOR_BYTES * 8;
    localparam int PAD_BITS    = NUM_BITS - 24;
    localparam int CNT_W       = $clog2(NUM_BITS);

    localparam int CHAN_W      = 8;
    localparam int TICK_W      = 15;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CHAN_W-1:0] BRIGHTNESS_RST      = 8'd128;
    localparam logic [TICK_W-1:0] ONE_HIGH_TICKS_RST  = 15'd8;
    localparam logic [TICK_W-1:0] ONE_LOW_TICKS_RST   = 15'd4;
    localparam logic [TICK_W-1:0] ZERO_HIGH_TICKS_RST = 15'd4;
    localparam logic [TICK_W-1:0] ZERO_LOW_TICKS_RST  = 15'd8;
    localparam logic [TICK_W-1:0] LATCH_TICKS_RST     = 15'd600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHTNESS      = 3'd0,
        CFG_ONE_HIGH_TICKS  = 3'd1,
        CFG_ONE_LOW_TICKS   = 3'd2,
        CFG_ZERO_HIGH_TICKS = 3'd3,
        CFG_ZERO_LOW_TICKS  = 3'd4,
        CFG_LATCH_TICKS     = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic mul_en;
        logic load_en;
        logic shift_en;
        logic sel_latch;
    } t_dp_cmd;

    typedef struct packed {
        logic last_bit;
    } t_dp_status;

    typedef struct packed {
        logic              first_level;
        logic [TICK_W-1:0] first_ticks;
        logic              second_level;
        logic [TICK_W-1:0] second_ticks;
        logic              last_symbol;
    } t_symbol;

endpackage

>>> hdl/ws_enc_if.sv
`timescale 1ns / 1ps
interface ws_enc_color_if import ws_enc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface ws_enc_symbol_if import ws_enc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              first_level;
    logic [TICK_W-1:0] first_ticks;
    logic              second_level;
    logic [TICK_W-1:0] second_ticks;
    logic              last_symbol;

    modport source (output valid, first_level, first_ticks, second_level, second_ticks,
                    last_symbol, input ready);
    modport sink   (input valid, first_level, first_ticks, second_level, second_ticks,
                    last_symbol, output ready);
endinterface

interface ws_enc_cfg_if import ws_enc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TICK_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/ws2812_color_symbol_encoder.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// i_cfg     in         index (3 bits), data (15 bits); always ready
// i_color   in         red, green, blue (8 bits each)
// o_symbol  out        first_level, first_ticks, second_level, second_ticks, last_symbol
//
// A color is accepted, scaled in the multiply state, then sent as 25 symbols, one
// per cycle while the sink is ready: bit shift register data, then the latch symbol.
// Reset (synchronous, active low) restores the register defaults and idles the block.
// A stalled sink holds the current symbol; no new color is taken until the
// closing latch symbol has been accepted.
module ws2812_color_symbol_encoder
    import ws_enc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    ws_enc_cfg_if.sink       i_cfg,
    ws_enc_color_if.sink     i_color,
    ws_enc_symbol_if.source  o_symbol
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_symbol    w_symbol;
    logic       w_cfg_we;

    // Registers are plain flops with no side effects, so writes never stall.
    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;

    // The controller sequences a color: capture, scale, shift out the data
    // bits, then the latch symbol.
    ws_enc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_color.valid),
        .o_in_ready  (i_color.ready),
        .o_out_valid (o_symbol.valid),
        .i_out_ready (o_symbol.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the registers, the scaling multipliers and the
    // bit shift register that picks each symbol's timing.
    ws_enc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_red       (i_color.red),
        .i_green     (i_color.green),
        .i_blue      (i_color.blue),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_symbol    (w_symbol)
    );

    assign o_symbol.first_level  = w_symbol.first_level;
    assign o_symbol.first_ticks  = w_symbol.first_ticks;
    assign o_symbol.second_level = w_symbol.second_level;
    assign o_symbol.second_ticks = w_symbol.second_ticks;
    assign o_symbol.last_symbol  = w_symbol.last_symbol;

`ifndef SYNTHESIS
    // Only one color is in flight: no symbol is offered while a new color is taken.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_symbol.valid && i_color.ready))
        else $error("input ready while a symbol is pending");

    // A taken color goes through the multiply state, then its first data symbol is offered.
    a_first_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_color.valid && i_color.ready) |-> ##2 (o_symbol.valid && !o_symbol.last_symbol))
        else $error("first data symbol missing after color accept");

    // The latch symbol closes the color and the block goes idle.
    a_latch_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_symbol.valid && o_symbol.ready && o_symbol.last_symbol)
        |=> (!o_symbol.valid && i_color.ready))
        else $error("block not idle after latch symbol");
`endif

endmodule

>>> hdl/ws_enc_ctrl.sv
`timescale 1ns / 1ps
module ws_enc_ctrl
    import ws_enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_SEND,
        S_LATCH
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   r_sel_latch;

    logic   w_in_acc;
    logic   w_out_acc;

    assign w_in_acc  = r_in_ready && i_in_valid;
    assign w_out_acc = r_out_valid && i_out_ready;

    always_comb begin
        o_cmd.mul_en    = w_in_acc;
        o_cmd.load_en   = (r_state == S_MUL);
        o_cmd.shift_en  = (r_state == S_SEND) && w_out_acc;
        o_cmd.sel_latch = r_sel_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
            r_sel_latch <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state    <= S_MUL;
                        r_in_ready <= 1'b0;
                    end
                end
                S_MUL: begin
                    r_state     <= S_SEND;
                    r_out_valid <= 1'b1;
                end
                S_SEND: begin
                    if (w_out_acc && i_status.last_bit) begin
                        r_state     <= S_LATCH;
                        r_sel_latch <= 1'b1;
                    end
                end
                S_LATCH: begin
                    if (w_out_acc) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_sel_latch <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                    r_sel_latch <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/ws_enc_dp.sv
`timescale 1ns / 1ps
module ws_enc_dp
    import ws_enc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_data,
    input  logic [CHAN_W-1:0]    i_red,
    input  logic [CHAN_W-1:0]    i_green,
    input  logic [CHAN_W-1:0]    i_blue,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output t_symbol              o_symbol
);

    localparam int PROD_W = 2 * CHAN_W;

    logic [CHAN_W-1:0]   r_brightness;
    logic [TICK_W-1:0]   r_one_high_ticks;
    logic [TICK_W-1:0]   r_one_low_ticks;
    logic [TICK_W-1:0]   r_zero_high_ticks;
    logic [TICK_W-1:0]   r_zero_low_ticks;
    logic [TICK_W-1:0]   r_latch_ticks;

    logic [PROD_W-1:0]   r_prod_r;
    logic [PROD_W-1:0]   r_prod_g;
    logic [PROD_W-1:0]   r_prod_b;
    logic [NUM_BITS-1:0] r_shift;
    logic [CNT_W-1:0]    r_count;

    logic [PROD_W:0]     w_sum_r;
    logic [PROD_W:0]     w_sum_g;
    logic [PROD_W:0]     w_sum_b;
    logic [23:0]         w_grb;
    logic                w_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness      <= BRIGHTNESS_RST;
            r_one_high_ticks  <= ONE_HIGH_TICKS_RST;
            r_one_low_ticks   <= ONE_LOW_TICKS_RST;
            r_zero_high_ticks <= ZERO_HIGH_TICKS_RST;
            r_zero_low_ticks  <= ZERO_LOW_TICKS_RST;
            r_latch_ticks     <= LATCH_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BRIGHTNESS:      r_brightness      <= i_cfg_data[CHAN_W-1:0];
                CFG_ONE_HIGH_TICKS:  r_one_high_ticks  <= i_cfg_data;
                CFG_ONE_LOW_TICKS:   r_one_low_ticks   <= i_cfg_data;
                CFG_ZERO_HIGH_TICKS: r_zero_high_ticks <= i_cfg_data;
                CFG_ZERO_LOW_TICKS:  r_zero_low_ticks  <= i_cfg_data;
                CFG_LATCH_TICKS:     r_latch_ticks     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod_r <= PROD_W'(i_red) * PROD_W'(r_brightness);
            r_prod_g <= PROD_W'(i_green) * PROD_W'(r_brightness);
            r_prod_b <= PROD_W'(i_blue) * PROD_W'(r_brightness);
        end
    end

    // floor(x / 255) for any x up to 255 * 255 is (x + (x >> 8) + 1) >> 8.
    assign w_sum_r = (PROD_W+1)'(r_prod_r) + (PROD_W+1)'(r_prod_r[PROD_W-1:CHAN_W])
                   + (PROD_W+1)'(1);
    assign w_sum_g = (PROD_W+1)'(r_prod_g) + (PROD_W+1)'(r_prod_g[PROD_W-1:CHAN_W])
                   + (PROD_W+1)'(1);
    assign w_sum_b = (PROD_W+1)'(r_prod_b) + (PROD_W+1)'(r_prod_b[PROD_W-1:CHAN_W])
                   + (PROD_W+1)'(1);
    assign w_grb   = {w_sum_g[PROD_W-1:CHAN_W], w_sum_r[PROD_W-1:CHAN_W],
                      w_sum_b[PROD_W-1:CHAN_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_count <= '0;
        end else if (i_cmd.load_en) begin
            r_shift <= NUM_BITS'(w_grb) << PAD_BITS;
            r_count <= '0;
        end else if (i_cmd.shift_en) begin
            r_shift <= r_shift << 1;
            r_count <= r_count + CNT_W'(1);
        end
    end

    assign o_status.last_bit = (r_count == CNT_W'(NUM_BITS - 1));

    assign w_bit = r_shift[NUM_BITS-1];

    always_comb begin
        if (i_cmd.sel_latch) begin
            o_symbol.first_level  = 1'b0;
            o_symbol.first_ticks  = r_latch_ticks;
            o_symbol.second_ticks = '0;
            o_symbol.last_symbol  = 1'b1;
        end else begin
            o_symbol.first_level  = 1'b1;
            o_symbol.first_ticks  = w_bit ? r_one_high_ticks : r_zero_high_ticks;
            o_symbol.second_ticks = w_bit ? r_one_low_ticks : r_zero_low_ticks;
            o_symbol.last_symbol  = 1'b0;
        end
        o_symbol.second_level = 1'b0;
    end

endmodule

>>> bench/ws_symbol_checker.sv
`timescale 1ns / 1ps
module ws_symbol_checker
    import ws_enc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    ws_enc_cfg_if    i_cfg,
    ws_enc_color_if  i_color,
    ws_enc_symbol_if i_symbol,
    output int       o_mismatches,
    output int       o_outstanding
);

    localparam int GRB_BITS     = 24;
    localparam int FULL_SCALE   = 255;
    localparam int REPORT_LIMIT = 10;

    // Shadow copies of the encoder settings.
    logic [CHAN_W-1:0] brightness;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] one_low;
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] latch_len;

    t_symbol expected_symbols[$];

    function automatic logic [CHAN_W-1:0] dim(input logic [CHAN_W-1:0] level,
                                              input logic [CHAN_W-1:0] scale);
        logic [2*CHAN_W-1:0] product;
        product = (2*CHAN_W)'(level) * (2*CHAN_W)'(scale);
        return CHAN_W'(product / FULL_SCALE);
    endfunction

    task automatic write_setting(input logic [CFG_IDX_W-1:0] index,
                                 input logic [TICK_W-1:0] value);
        case (index)
            CFG_BRIGHTNESS:      brightness = value[CHAN_W-1:0];
            CFG_ONE_HIGH_TICKS:  one_high   = value;
            CFG_ONE_LOW_TICKS:   one_low    = value;
            CFG_ZERO_HIGH_TICKS: zero_high  = value;
            CFG_ZERO_LOW_TICKS:  zero_low   = value;
            CFG_LATCH_TICKS:     latch_len  = value;
            default: ;
        endcase
    endtask

    // Bits leave the GRB word from the top; once 24 have gone the word is all
    // zeros, so any padding byte comes out as zero bits.
    task automatic encode_color(input logic [CHAN_W-1:0] r,
                                input logic [CHAN_W-1:0] g,
                                input logic [CHAN_W-1:0] b);
        logic [GRB_BITS-1:0] grb;
        logic                bit_val;
        t_symbol             sym;
        grb = {dim(g, brightness), dim(r, brightness), dim(b, brightness)};
        for (int i = 0; i < NUM_BITS; i++) begin
            bit_val          = grb[GRB_BITS-1];
            grb              = grb << 1;
            sym.first_level  = 1'b1;
            sym.first_ticks  = bit_val ? one_high : zero_high;
            sym.second_level = 1'b0;
            sym.second_ticks = bit_val ? one_low : zero_low;
            sym.last_symbol  = 1'b0;
            expected_symbols.push_back(sym);
        end
        sym.first_level  = 1'b0;
        sym.first_ticks  = latch_len;
        sym.second_level = 1'b0;
        sym.second_ticks = '0;
        sym.last_symbol  = 1'b1;
        expected_symbols.push_back(sym);
    endtask

    task automatic check_symbol(input t_symbol got);
        t_symbol want;
        if (expected_symbols.size() == 0) begin
            o_mismatches++;
            if (o_mismatches <= REPORT_LIMIT)
                $display("%0t: unexpected symbol %0b/%0d/%0b/%0d/%0b", $realtime,
                         got.first_level, got.first_ticks, got.second_level,
                         got.second_ticks, got.last_symbol);
            return;
        end
        want = expected_symbols.pop_front();
        if (got.first_level !== want.first_level || got.first_ticks !== want.first_ticks ||
            got.second_level !== want.second_level ||
            got.second_ticks !== want.second_ticks || got.last_symbol !== want.last_symbol) begin
            o_mismatches++;
            if (o_mismatches <= REPORT_LIMIT)
                $display("%0t: symbol mismatch, expected %0b/%0d/%0b/%0d/%0b got %0b/%0d/%0b/%0d/%0b",
                         $realtime, want.first_level, want.first_ticks, want.second_level,
                         want.second_ticks, want.last_symbol, got.first_level, got.first_ticks,
                         got.second_level, got.second_ticks, got.last_symbol);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            brightness = BRIGHTNESS_RST;
            one_high   = ONE_HIGH_TICKS_RST;
            one_low    = ONE_LOW_TICKS_RST;
            zero_high  = ZERO_HIGH_TICKS_RST;
            zero_low   = ZERO_LOW_TICKS_RST;
            latch_len  = LATCH_TICKS_RST;
            expected_symbols.delete();
            o_outstanding <= 0;
        end else begin
            if (i_symbol.valid && i_symbol.ready)
                check_symbol({i_symbol.first_level, i_symbol.first_ticks, i_symbol.second_level,
                              i_symbol.second_ticks, i_symbol.last_symbol});
            if (i_cfg.valid && i_cfg.ready)
                write_setting(i_cfg.index, i_cfg.data);
            if (i_color.valid && i_color.ready)
                encode_color(i_color.red, i_color.green, i_color.blue);
            o_outstanding <= expected_symbols.size();
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import ws_enc_pkg::*;

    // Random traffic is split into phases; each phase starts from an idle
    // encoder with a fresh set of timing and brightness settings.
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 69;
    // Percentage of cycles in which either side idles.
    localparam int IDLE_PCT        = 30;
    // The one long hold-off of the symbol sink, in cycles.
    localparam int HOLD_CYCLES     = 300;
    // Covers a whole color passing through a ready encoder, with margin.
    localparam int DRAIN_CYCLES    = 32;
    // Cycles without any item accepted on any channel before the run is ended.
    localparam int STALL_LIMIT     = 3000;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [TICK_W-1:0]    TICKS_MAX    = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic steady;        // When high, neither side idles.
    logic hold_request;  // Asks the symbol sink for its long hold-off.
    logic hold_done;
    int   hold_left;
    int   stall_count;
    int   mismatches;
    int   outstanding;

    ws_enc_cfg_if    cfg_bus();
    ws_enc_color_if  color_bus();
    ws_enc_symbol_if symbol_bus();

    ws2812_color_symbol_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_color (color_bus),
        .o_symbol(symbol_bus)
    );

    ws_symbol_checker symbol_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_bus),
        .i_color      (color_bus),
        .i_symbol     (symbol_bus),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 0;
    end

    // Symbol sink. It normally drops ready at random, but once during the run
    // it holds ready low for a long stretch so that the encoder fills up and
    // has to refuse new colors while the sender keeps offering them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            symbol_bus.ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            symbol_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            symbol_bus.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            symbol_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: a correct encoder always moves an item on some channel well
    // within the limit, even through the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cfg_bus.valid && cfg_bus.ready) ||
            (color_bus.valid && color_bus.ready) || (symbol_bus.valid && symbol_bus.ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Channel values are picked so that both extremes come up often.
    function automatic logic [CHAN_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_ticks();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return TICKS_MAX;
            default: return TICK_W'($urandom);
        endcase
    endfunction

    // Valid is left high after an accepted write so that back-to-back writes
    // never lower and raise it within the same time step; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [TICK_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
    endtask

    // Writes every register, then the two unused indexes with random data,
    // which the encoder has to ignore.
    task automatic program_encoder(input logic [TICK_W-1:0] level,
                                   input logic [TICK_W-1:0] one_high,
                                   input logic [TICK_W-1:0] one_low,
                                   input logic [TICK_W-1:0] zero_high,
                                   input logic [TICK_W-1:0] zero_low,
                                   input logic [TICK_W-1:0] latch_len);
        write_reg(CFG_BRIGHTNESS, level);
        write_reg(CFG_ONE_HIGH_TICKS, one_high);
        write_reg(CFG_ONE_LOW_TICKS, one_low);
        write_reg(CFG_ZERO_HIGH_TICKS, zero_high);
        write_reg(CFG_ZERO_LOW_TICKS, zero_low);
        write_reg(CFG_LATCH_TICKS, latch_len);
        write_reg(CFG_SPARE_LO, TICK_W'($urandom));
        write_reg(CFG_SPARE_HI, TICK_W'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    // Offers one color after an optional random gap. Valid stays high after
    // the item is accepted; the next call or the drain step lowers it.
    task automatic offer_color(input logic [CHAN_W-1:0] r,
                               input logic [CHAN_W-1:0] g,
                               input logic [CHAN_W-1:0] b);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            color_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        color_bus.valid <= 1'b1;
        color_bus.red   <= r;
        color_bus.green <= g;
        color_bus.blue  <= b;
        do @(posedge i_clk); while (!color_bus.ready);
    endtask

    // Waits until every expected symbol has come out, then gives the encoder
    // its full latency to settle before any register is touched.
    task automatic drain_encoder();
        color_bus.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        steady           <= 1'b0;
        hold_request     <= 1'b0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= '0;
        cfg_bus.data     <= '0;
        color_bus.valid  <= 1'b0;
        color_bus.red    <= '0;
        color_bus.green  <= '0;
        color_bus.blue   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: half brightness and the default pulse widths.
        offer_color(8'hFF, 8'h80, 8'h01);
        offer_color(8'd200, 8'd100, 8'd50);
        drain_encoder();

        // Full brightness passes the channels through unscaled, so the bit
        // patterns below come out exactly as written.
        program_encoder(15'd255, 15'd11, 15'd5, 15'd3, 15'd9, 15'd777);
        offer_color(8'h00, 8'h00, 8'h00);
        offer_color(8'hFF, 8'hFF, 8'hFF);
        offer_color(8'hFF, 8'h00, 8'h00);
        offer_color(8'h00, 8'hFF, 8'h00);
        offer_color(8'h00, 8'h00, 8'hFF);
        offer_color(8'hAA, 8'h55, 8'hAA);
        offer_color(8'h55, 8'hAA, 8'h55);
        offer_color(8'h01, 8'h80, 8'h7F);
        drain_encoder();

        // Zero brightness blanks every channel, and all durations are zero.
        program_encoder(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0);
        offer_color(8'hFF, 8'hFF, 8'hFF);
        offer_color(8'h80, 8'h01, 8'hFE);
        drain_encoder();

        // Brightness of one leaves only a full-scale channel at one; all
        // durations at their maximum. The upper data bits of the brightness
        // write are set and must be dropped.
        program_encoder({7'h7F, 8'h01}, TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX);
        offer_color(8'hFF, 8'hFF, 8'hFF);
        offer_color(8'hFE, 8'h01, 8'h00);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_encoder();
            program_encoder({7'($urandom), pick_level()}, pick_ticks(), pick_ticks(),
                            pick_ticks(), pick_ticks(), pick_ticks());
            // The second phase carries the long sink hold-off; the fourth runs
            // with no idling at all on either side.
            if (p == 1)
                hold_request <= 1'b1;
            steady <= (p == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                offer_color(pick_level(), pick_level(), pick_level());
        end

        drain_encoder();
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
